// File: rtl/frl_pkg.sv
// ----------------------------------------------------------------------------
// frl_pkg
// types and constants for the fixed-window rate limiter
// ----------------------------------------------------------------------------
package frl_pkg;

    localparam int FRL_KEY_ENTRIES = 256;
    localparam int KEY_SPACE       = 256;
    localparam int CFG_IDX_W       = 1;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

    localparam logic [15:0] LIMIT_RESET  = 16'd100;
    localparam logic [15:0] WINDOW_RESET = 16'd60;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] key_index;
    } t_req;

    typedef struct packed {
        logic        allowed;
        logic [15:0] remaining;
        logic [15:0] seconds_to_reset;
        logic [31:0] refused_total;
    } t_resp;

    typedef struct packed {
        logic [15:0] count;
        logic [31:0] start;
    } t_entry;

endpackage

// File: rtl/fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter
// per-key fixed-window limiter on a read-modify-write entry memory
// ----------------------------------------------------------------------------
// result strobe raised at the edge after the accepting edge
// throughput: one item per cycle outside reset, set by the read-modify-write
//   of the entry memory with write-to-read forwarding
// reset: seen flags, clock, refusal total and valid flags clear at once; no sweep
// results cannot be held off by the receiver
module fixed_window_rate_limiter
    import frl_pkg::*;
#(
    parameter int KEY_ENTRIES = FRL_KEY_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_done,
    output t_resp                o_resp
);

    localparam int ROWS = (KEY_ENTRIES < KEY_SPACE) ? KEY_ENTRIES : KEY_SPACE;
    localparam int IW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [IW-1:0] w_key_map [KEY_SPACE];

    for (genvar k = 0; k < KEY_SPACE; k++) begin : g_key_map
        assign w_key_map[k] = IW'(k % ROWS);
    end

    t_entry        r_entries [ROWS];
    t_entry        r_rd;
    logic [ROWS-1:0] r_seen;
    logic [15:0]   r_limit;
    logic [15:0]   r_window;
    logic [31:0]   r_now;
    logic [31:0]   r_refusals;
    logic          r_s1_valid;
    logic [1:0]    r_s1_op;
    logic [IW-1:0] r_s1_idx;

    logic          w_accept;
    logic [IW-1:0] w_idx;
    logic          w_is_req;
    logic          w_is_peek;
    logic          w_seen;
    logic [31:0]   w_el;
    logic          w_over;
    logic          w_restart;
    logic [15:0]   w_cnt_eff;
    logic          w_grant;
    logic          w_rep_seen;
    logic          w_rep_over;
    logic [15:0]   w_rep_el;
    logic [15:0]   w_rep_cnt;
    t_entry        n_entry;
    logic [31:0]   n_refusals;
    logic [31:0]   n_now;
    t_resp         n_resp;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;
    assign w_idx       = w_key_map[i_req.key_index];

    assign w_is_req  = r_s1_valid && (r_s1_op == OP_REQUEST);
    assign w_is_peek = r_s1_valid && (r_s1_op == OP_PEEK);

    always_comb begin
        w_seen    = r_seen[r_s1_idx];
        w_el      = r_now - r_rd.start;
        w_over    = w_el >= {16'd0, r_window};
        w_restart = !w_seen || (r_rd.count == 16'd0) || w_over;
        w_cnt_eff = w_restart ? 16'd0 : r_rd.count;
        w_grant   = w_cnt_eff < r_limit;

        n_entry.count = w_cnt_eff + {15'd0, w_grant};
        n_entry.start = w_restart ? r_now : r_rd.start;

        w_rep_seen = w_is_req || w_seen;
        w_rep_over = w_is_req ? (w_restart && (r_window == 16'd0)) : w_over;
        w_rep_el   = (w_is_req && w_restart) ? 16'd0 : w_el[15:0];
        w_rep_cnt  = w_is_req ? n_entry.count : r_rd.count;

        n_resp.allowed = w_is_req && w_grant;
        if (!w_rep_seen || w_rep_over) begin
            n_resp.remaining = r_limit;
        end else if (w_rep_cnt >= r_limit) begin
            n_resp.remaining = 16'd0;
        end else begin
            n_resp.remaining = r_limit - w_rep_cnt;
        end
        if (!w_rep_seen) begin
            n_resp.seconds_to_reset = r_window;
        end else if (w_rep_over) begin
            n_resp.seconds_to_reset = 16'd0;
        end else begin
            n_resp.seconds_to_reset = r_window - w_rep_el;
        end

        n_refusals = r_refusals;
        if (w_is_req && !w_grant && (r_refusals != '1)) begin
            n_refusals = r_refusals + 32'd1;
        end
        n_resp.refused_total = n_refusals;

        n_now = r_now;
        if (r_s1_valid && (r_s1_op == OP_TICK)) begin
            n_now = r_now + 32'd1;
        end
    end

    // entry memory, read-before-write with forwarding of the same-edge write
    always_ff @(posedge i_clk) begin
        if (w_is_req) begin
            r_entries[r_s1_idx] <= n_entry;
        end
        if (w_is_req && (r_s1_idx == w_idx)) begin
            r_rd <= n_entry;
        end else begin
            r_rd <= r_entries[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op  <= i_req.opcode;
            r_s1_idx <= w_idx;
        end
        if (w_is_req || w_is_peek) begin
            o_resp <= n_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_seen     <= '0;
            r_limit    <= LIMIT_RESET;
            r_window   <= WINDOW_RESET;
            r_now      <= 32'd0;
            r_refusals <= 32'd0;
            o_done     <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_now      <= n_now;
            r_refusals <= n_refusals;
            o_done     <= w_is_req || w_is_peek;
            if (w_is_req) begin
                r_seen[r_s1_idx] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LIMIT:  r_limit  <= i_cfg_data;
                    CFG_WINDOW: r_window <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_s1_valid && ((r_s1_op == OP_REQUEST) || (r_s1_op == OP_PEEK))))
        else $error("result strobe without a request or peek in flight");

    a_grant_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_resp.allowed) |-> $past(r_s1_op == OP_REQUEST))
        else $error("grant reported for a non-request");

    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_resp.refused_total == r_refusals))
        else $error("reported refusal total differs from the counter");

    a_refusals_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_refusals >= $past(r_refusals)))
        else $error("refusal total went down");
`endif

endmodule
